// File: rtl/gorb_pkg.sv
// Package: shared types, constants and report layout functions for the report builder.
`default_nettype none

package gorb_pkg;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [2:0] REG_TYPE   = 3'd0;
    localparam logic [2:0] REG_BT     = 3'd1;
    localparam logic [2:0] REG_CONN   = 3'd2;
    localparam logic [2:0] REG_GAIN   = 3'd3;
    localparam logic [2:0] REG_BRIGHT = 3'd4;

    localparam logic [7:0] GAIN_RESET   = 8'd100;
    localparam logic [7:0] BRIGHT_RESET = 8'd80;
    localparam logic [7:0] PCT_MAX      = 8'd100;
    localparam logic [6:0] GAIN_DEFAULT   = 7'd100;
    localparam logic [6:0] BRIGHT_DEFAULT = 7'd80;

    localparam logic [12:0] RECIP_100   = 13'd5243;
    localparam int          RECIP_SHIFT = 19;

    localparam logic [1:0] TYPE_FIRST  = 2'd0;
    localparam logic [1:0] TYPE_SECOND = 2'd1;

    localparam logic [1:0] LAYOUT_FIRST_USB  = 2'b00;
    localparam logic [1:0] LAYOUT_FIRST_BT   = 2'b01;
    localparam logic [1:0] LAYOUT_SECOND_USB = 2'b10;
    localparam logic [1:0] LAYOUT_SECOND_BT  = 2'b11;

    localparam logic [7:0] ID_FIRST_USB  = 8'h05;
    localparam logic [7:0] ID_FIRST_BT   = 8'h11;
    localparam logic [7:0] ID_SECOND_USB = 8'h02;
    localparam logic [7:0] ID_SECOND_BT  = 8'h31;
    localparam logic [7:0] BT_HEADER     = 8'hA2;

    localparam logic [4:0] LAST_FIRST_USB  = 5'd7;
    localparam logic [4:0] LAST_SECOND_USB = 5'd11;
    localparam logic [4:0] LAST_BT         = 5'd19;
    localparam logic [4:0] CRC_WORD        = 5'd18;

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;

    typedef struct packed {
        logic [1:0] ctype;
        logic       bt;
        logic       conn;
        logic [7:0] gain;
        logic [7:0] bright;
    } gorb_cfg_t;

    typedef struct packed {
        logic       family;
        logic       bt;
        logic [7:0] strong_amp;
        logic [7:0] weak_amp;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] player;
    } gorb_entry_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
        logic [31:0] c;
        c = crc ^ {24'h0, data};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [31:0] crc_half(input logic [31:0] crc, input logic [15:0] data);
        logic [31:0] c;
        c = crc;
        for (int k = 0; k < 16; k++) begin
            c = (c[0] ^ data[k]) ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [31:0] crc_word(input logic [31:0] crc, input logic [31:0] data);
        logic [31:0] c;
        c = crc;
        for (int k = 0; k < 32; k++) begin
            c = (c[0] ^ data[k]) ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    localparam logic [31:0] CRC_SEED = crc_byte(32'hFFFFFFFF, BT_HEADER);

    function automatic logic [7:0] player_byte(input logic [7:0] mode);
        logic [7:0] b;
        case (mode)
            8'd0:    b = 8'h00;
            8'd1:    b = 8'h04;
            8'd2:    b = 8'h06;
            8'd3:    b = 8'h15;
            8'd4:    b = 8'h1B;
            8'd5:    b = 8'h1F;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] report_byte(input gorb_entry_t e, input logic [6:0] pos);
        logic [7:0] b;
        b = 8'h00;
        case ({e.family, e.bt})
            LAYOUT_FIRST_USB: begin
                case (pos)
                    7'd0:    b = ID_FIRST_USB;
                    7'd1:    b = 8'h07;
                    7'd4:    b = e.strong_amp;
                    7'd5:    b = e.weak_amp;
                    7'd6:    b = e.red;
                    7'd7:    b = e.green;
                    7'd8:    b = e.blue;
                    default: b = 8'h00;
                endcase
            end
            LAYOUT_FIRST_BT: begin
                case (pos)
                    7'd0:    b = ID_FIRST_BT;
                    7'd1:    b = 8'h80;
                    7'd3:    b = 8'h03;
                    7'd6:    b = e.weak_amp;
                    7'd7:    b = e.strong_amp;
                    7'd8:    b = e.red;
                    7'd9:    b = e.green;
                    7'd10:   b = e.blue;
                    default: b = 8'h00;
                endcase
            end
            LAYOUT_SECOND_USB: begin
                case (pos)
                    7'd0:    b = ID_SECOND_USB;
                    7'd1:    b = 8'h13;
                    7'd2:    b = 8'h17;
                    7'd3:    b = e.weak_amp;
                    7'd4:    b = e.strong_amp;
                    7'd40:   b = 8'h02;
                    7'd44:   b = e.player;
                    7'd45:   b = e.red;
                    7'd46:   b = e.green;
                    7'd47:   b = e.blue;
                    default: b = 8'h00;
                endcase
            end
            LAYOUT_SECOND_BT: begin
                case (pos)
                    7'd0:    b = ID_SECOND_BT;
                    7'd1:    b = 8'h02;
                    7'd2:    b = 8'h13;
                    7'd3:    b = 8'h17;
                    7'd4:    b = e.weak_amp;
                    7'd5:    b = e.strong_amp;
                    7'd41:   b = 8'h02;
                    7'd45:   b = e.player;
                    7'd46:   b = e.red;
                    7'd47:   b = e.green;
                    7'd48:   b = e.blue;
                    default: b = 8'h00;
                endcase
            end
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// File: rtl/gorb_front.sv
// Front end: accept requests, drop suppressed ones, scale levels over two pipeline stages.
`default_nettype none

module gorb_front
    import gorb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        accept,
    input  wire gorb_cfg_t   cfg,
    input  wire logic [7:0]  strong_motor,
    input  wire logic [7:0]  weak_motor,
    input  wire logic [7:0]  red_level,
    input  wire logic [7:0]  green_level,
    input  wire logic [7:0]  blue_level,
    input  wire logic [7:0]  player_mode,
    output logic             push,
    output gorb_entry_t      push_entry,
    output logic [1:0]       inflight
);

    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic        s2_valid_reg;
    logic        family_reg;
    logic        bt_reg;
    logic [7:0]  player_reg;
    logic [14:0] prod_reg [5];
    gorb_entry_t entry_reg;

    logic [6:0]  gain;
    logic [6:0]  bright;
    logic [7:0]  q [5];
    logic [27:0] scaled [5];

    assign gain   = (cfg.gain > PCT_MAX) ? GAIN_DEFAULT : cfg.gain[6:0];
    assign bright = (cfg.bright > PCT_MAX) ? BRIGHT_DEFAULT : cfg.bright[6:0];

    assign s1_valid_next = accept && cfg.conn &&
                           (cfg.ctype == TYPE_FIRST || cfg.ctype == TYPE_SECOND);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            family_reg  <= cfg.ctype[0];
            bt_reg      <= cfg.bt;
            player_reg  <= player_byte(player_mode);
            prod_reg[0] <= 15'(strong_motor * gain);
            prod_reg[1] <= 15'(weak_motor * gain);
            prod_reg[2] <= 15'(red_level * bright);
            prod_reg[3] <= 15'(green_level * bright);
            prod_reg[4] <= 15'(blue_level * bright);
        end
    end

    always_comb
    begin
        for (int i = 0; i < 5; i++)
        begin
            scaled[i] = {13'h0, prod_reg[i]} * {15'h0, RECIP_100};
            q[i]      = scaled[i][RECIP_SHIFT +: 8];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            entry_reg.family     <= family_reg;
            entry_reg.bt         <= bt_reg;
            entry_reg.player     <= player_reg;
            entry_reg.strong_amp <= q[0];
            entry_reg.weak_amp   <= q[1];
            entry_reg.red        <= q[2];
            entry_reg.green      <= q[3];
            entry_reg.blue       <= q[4];
        end
    end

    assign push       = s2_valid_reg;
    assign push_entry = entry_reg;
    assign inflight   = {1'b0, s1_valid_reg} + {1'b0, s2_valid_reg};

endmodule

`default_nettype wire

// File: rtl/gorb_queue.sv
// Short queue of classified requests between the front end and the word sequencer.
`default_nettype none

module gorb_queue
    import gorb_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire gorb_entry_t  push_entry,
    input  wire logic         pop,
    output gorb_entry_t       head,
    output logic              nonempty,
    output logic [QCNT_W-1:0] count
);

    gorb_entry_t       mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign head     = mem_reg[rd_ptr_reg];
    assign nonempty = (count_reg != '0);
    assign count    = count_reg;

endmodule

`default_nettype wire

// File: rtl/gorb_back.sv
// Back end: emit report words one per cycle and fold in the trailing CRC-32.
`default_nettype none

module gorb_back
    import gorb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire gorb_entry_t head,
    input  wire logic        nonempty,
    output logic             pop,
    output logic             strobe,
    output logic [31:0]      report_word,
    output logic [2:0]       bytes_valid,
    output logic             last_word
);

    logic        active_reg;
    logic        active_next;
    logic [4:0]  idx_reg;
    logic [4:0]  idx_next;
    logic [31:0] crc_reg;
    logic [31:0] crc_next;
    gorb_entry_t entry_reg;

    logic        strobe_reg;
    logic [31:0] word_reg;
    logic [2:0]  valid_reg;
    logic        last_reg;

    logic [4:0]  last_idx;
    logic        last_now;
    logic [6:0]  base;
    logic [31:0] data_word;
    logic [31:0] crc_tail;
    logic [31:0] word;
    logic [2:0]  nvalid;

    always_comb
    begin
        case ({entry_reg.family, entry_reg.bt})
            LAYOUT_FIRST_USB:  last_idx = LAST_FIRST_USB;
            LAYOUT_SECOND_USB: last_idx = LAST_SECOND_USB;
            default:           last_idx = LAST_BT;
        endcase
    end

    assign last_now = active_reg && (idx_reg == last_idx);
    assign pop      = nonempty && (!active_reg || last_now);
    assign base     = {idx_reg, 2'b00};

    assign data_word = {report_byte(entry_reg, base + 7'd3),
                        report_byte(entry_reg, base + 7'd2),
                        report_byte(entry_reg, base + 7'd1),
                        report_byte(entry_reg, base)};

    assign crc_tail = crc_half(crc_reg, data_word[15:0]) ^ 32'hFFFFFFFF;

    always_comb
    begin
        word     = data_word;
        nvalid   = 3'd4;
        crc_next = crc_word(crc_reg, data_word);
        if (entry_reg.bt && idx_reg == CRC_WORD)
        begin
            word     = {crc_tail[15:0], data_word[15:0]};
            crc_next = crc_tail;
        end
        else if (entry_reg.bt && idx_reg == LAST_BT)
        begin
            word     = {16'h0000, crc_reg[31:16]};
            nvalid   = 3'd2;
            crc_next = crc_reg;
        end
        if (pop)
        begin
            crc_next = CRC_SEED;
        end
    end

    always_comb
    begin
        active_next = active_reg;
        idx_next    = idx_reg;
        if (pop)
        begin
            active_next = 1'b1;
            idx_next    = '0;
        end
        else if (last_now)
        begin
            active_next = 1'b0;
        end
        else if (active_reg)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            idx_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            idx_reg    <= idx_next;
            strobe_reg <= active_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        crc_reg   <= crc_next;
        word_reg  <= word;
        valid_reg <= nvalid;
        last_reg  <= last_now;
        if (pop)
        begin
            entry_reg <= head;
        end
    end

    assign strobe      = strobe_reg;
    assign report_word = word_reg;
    assign bytes_valid = valid_reg;
    assign last_word   = last_reg;

endmodule

`default_nettype wire

// File: rtl/gamepad_output_report_builder_unit.sv
// Top level: register port, front end, request queue and word sequencer.
// When idle, a request from start passes front stages 1 and 2 and the queue, then the
// sequencer strobes out its words: 8, 12 or 20 per report (first wired, second wired, wireless),
// one 32-bit word per cycle; back-to-back reports have no gap if the next one is queued.
// busy rises once the two front stages and the queue together hold four requests.
// Reset: gain 100, brightness 80, other registers 0, queue and pipeline empty.
`default_nettype none

module gamepad_output_report_builder_unit
    import gorb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [7:0]  strong_motor,
    input  wire logic [7:0]  weak_motor,
    input  wire logic [7:0]  red_level,
    input  wire logic [7:0]  green_level,
    input  wire logic [7:0]  blue_level,
    input  wire logic [7:0]  player_mode,
    output logic             strobe,
    output logic [31:0]      report_word,
    output logic [2:0]       bytes_valid,
    output logic             last_word,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    gorb_cfg_t         cfg_reg;
    logic              wr_en;
    logic [2:0]        reg_idx;
    logic              accept;
    logic              push;
    gorb_entry_t       push_entry;
    logic [1:0]        inflight;
    gorb_entry_t       head;
    logic              nonempty;
    logic [QCNT_W-1:0] q_count;
    logic              pop;
    logic [QCNT_W:0]   occupancy;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ctype  <= TYPE_FIRST;
            cfg_reg.bt     <= 1'b0;
            cfg_reg.conn   <= 1'b0;
            cfg_reg.gain   <= GAIN_RESET;
            cfg_reg.bright <= BRIGHT_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_TYPE:   cfg_reg.ctype  <= pwdata[1:0];
                REG_BT:     cfg_reg.bt     <= pwdata[0];
                REG_CONN:   cfg_reg.conn   <= pwdata[0];
                REG_GAIN:   cfg_reg.gain   <= pwdata[7:0];
                REG_BRIGHT: cfg_reg.bright <= pwdata[7:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_TYPE:   prdata = {30'h0, cfg_reg.ctype};
            REG_BT:     prdata = {31'h0, cfg_reg.bt};
            REG_CONN:   prdata = {31'h0, cfg_reg.conn};
            REG_GAIN:   prdata = {24'h0, cfg_reg.gain};
            REG_BRIGHT: prdata = {24'h0, cfg_reg.bright};
            default:    prdata = 32'h0;
        endcase
    end

    assign occupancy = {1'b0, q_count} + (QCNT_W + 1)'(inflight);
    assign busy      = (occupancy >= (QCNT_W + 1)'(QDEPTH));
    assign accept    = start && !busy;

    gorb_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .cfg          (cfg_reg),
        .strong_motor (strong_motor),
        .weak_motor   (weak_motor),
        .red_level    (red_level),
        .green_level  (green_level),
        .blue_level   (blue_level),
        .player_mode  (player_mode),
        .push         (push),
        .push_entry   (push_entry),
        .inflight     (inflight)
    );

    gorb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .nonempty   (nonempty),
        .count      (q_count)
    );

    gorb_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .nonempty    (nonempty),
        .pop         (pop),
        .strobe      (strobe),
        .report_word (report_word),
        .bytes_valid (bytes_valid),
        .last_word   (last_word)
    );

endmodule

`default_nettype wire
